// ===== rtl/fptw_pkg.sv =====
// fptw_pkg: shared types, codes and constants of the four-level page-table walker
// no dependencies
package fptw_pkg;

  localparam int TABLE_FRAMES = 64;
  localparam int FRAME_BITS   = $clog2(TABLE_FRAMES);
  localparam int SLOT_BITS    = FRAME_BITS + 9;

  typedef enum logic [2:0] {
    ACT_WRITE     = 3'd0,
    ACT_READ      = 3'd1,
    ACT_MAP       = 3'd2,
    ACT_UNMAP     = 3'd3,
    ACT_TRANSLATE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISALIGN = 2'd1,
    ST_MISSING  = 2'd2,
    ST_PRESENT  = 2'd3
  } status_t;

  localparam logic [1:0] CFG_ROOT  = 2'd0;
  localparam logic [1:0] CFG_BASE  = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_EVAL,
    S_ZERO,
    S_LINK,
    S_LEAF,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [63:0] map_flags;
    logic [51:0] word_addr;
    logic [63:0] word_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [51:0] result_addr;
    logic [63:0] read_data;
  } out_item_t;

  // store port request from the sequencer
  typedef struct packed {
    logic                 wr_en;
    logic [SLOT_BITS-1:0] addr;
    logic [63:0]          wdata;
  } store_req_t;

  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [51:0] a);
    slot_of = {a[12 +: FRAME_BITS], a[11:3]};
  endfunction

endpackage

// ===== rtl/four_level_page_table_walker.sv =====
// four_level_page_table_walker: top level, sequencer around the table store
// depends on fptw_pkg and fptw_store
//
// One item at a time: in_ready is high only while idle. A write word goes through decode
// and done, a read word through decode, a read wait and done. A misaligned map or unmap
// or an unknown action goes from decode straight to done. A translate goes through decode,
// a read issue and an evaluation per level, then done. An unmap or a map that writes its
// leaf adds the leaf write. A map that creates a level first clears each new frame with
// 512 zeroing writes through the single store port, then writes the link; a map may create
// all three upper levels. The result stays in an output register until taken, and the
// next item runs meanwhile. An item waits in its done state only while that register
// still holds an untaken result.
// The store has no reset: read a word only after writing it.
module four_level_page_table_walker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fptw_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fptw_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data
);

  fptw_pkg::state_t    state_r, state_nxt;
  fptw_pkg::in_item_t  item_r;
  fptw_pkg::out_item_t res_r, res_nxt;
  fptw_pkg::out_item_t acc_r;               // result being built for the current item
  logic                out_valid_r;
  logic [51:0]         root_r, base_r;
  logic [6:0]          count_r, alloc_r, alloc_nxt;
  logic [1:0]          lvl_r, lvl_nxt;
  logic [51:0]         table_r, table_nxt;   // current table base, low 12 zero
  logic [51:0]         frame_r, frame_nxt;   // newly allocated frame
  logic [8:0]          zcnt_r, zcnt_nxt;
  logic [63:0]         rdata;
  fptw_pkg::store_req_t req;
  logic [8:0]          idx;
  logic [51:0]         ea;
  logic                is_map;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == fptw_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;
  assign is_map    = (item_r.action == fptw_pkg::ACT_MAP);

  // virtual index of the current level
  always_comb begin
    case (lvl_r)
      2'd0:    idx = item_r.virt_addr[47:39];
      2'd1:    idx = item_r.virt_addr[38:30];
      2'd2:    idx = item_r.virt_addr[29:21];
      default: idx = item_r.virt_addr[20:12];
    endcase
    ea = {table_r[51:12], idx, 3'b000};
  end

  fptw_store u_store (.clk(clk), .req(req), .rdata(rdata));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fptw_pkg::S_IDLE:   if (in_valid) state_nxt = fptw_pkg::S_DECODE;
      fptw_pkg::S_DECODE: begin
        case (item_r.action)
          fptw_pkg::ACT_WRITE: state_nxt = fptw_pkg::S_DONE;
          fptw_pkg::ACT_READ:  state_nxt = fptw_pkg::S_RD_WAIT;
          fptw_pkg::ACT_MAP: begin
            if (item_r.virt_addr[11:0] != '0 || item_r.phys_addr[11:0] != '0)
              state_nxt = fptw_pkg::S_DONE;
            else
              state_nxt = fptw_pkg::S_RD_ISSUE;
          end
          fptw_pkg::ACT_UNMAP: begin
            if (item_r.virt_addr[11:0] != '0) state_nxt = fptw_pkg::S_DONE;
            else state_nxt = fptw_pkg::S_RD_ISSUE;
          end
          fptw_pkg::ACT_TRANSLATE: state_nxt = fptw_pkg::S_RD_ISSUE;
          default: state_nxt = fptw_pkg::S_DONE;
        endcase
      end
      fptw_pkg::S_RD_ISSUE: state_nxt = fptw_pkg::S_EVAL;
      fptw_pkg::S_RD_WAIT:  state_nxt = fptw_pkg::S_DONE;
      fptw_pkg::S_EVAL: begin
        if (lvl_r == 2'd3) begin
          if (is_map && !rdata[0]) state_nxt = fptw_pkg::S_LEAF;
          else if (item_r.action == fptw_pkg::ACT_UNMAP && rdata[0])
            state_nxt = fptw_pkg::S_LEAF;
          else state_nxt = fptw_pkg::S_DONE;
        end else if (rdata[0]) begin
          state_nxt = fptw_pkg::S_RD_ISSUE;
        end else if (is_map && alloc_r < count_r) begin
          state_nxt = fptw_pkg::S_ZERO;
        end else begin
          state_nxt = fptw_pkg::S_DONE;
        end
      end
      fptw_pkg::S_ZERO: if (zcnt_r == 9'h1FF) state_nxt = fptw_pkg::S_LINK;
      fptw_pkg::S_LINK: state_nxt = fptw_pkg::S_RD_ISSUE;
      fptw_pkg::S_LEAF: state_nxt = fptw_pkg::S_DONE;
      fptw_pkg::S_DONE: if (!out_valid_r || out_ready) state_nxt = fptw_pkg::S_IDLE;
      default: state_nxt = fptw_pkg::S_IDLE;
    endcase
  end

  // datapath and store requests
  always_comb begin
    res_nxt   = acc_r;
    lvl_nxt   = lvl_r;
    table_nxt = table_r;
    frame_nxt = frame_r;
    zcnt_nxt  = zcnt_r;
    alloc_nxt = alloc_r;
    req.wr_en = 1'b0;
    req.addr  = fptw_pkg::slot_of(ea);
    req.wdata = '0;
    case (state_r)
      fptw_pkg::S_DECODE: begin
        res_nxt   = '0;
        lvl_nxt   = 2'd0;
        table_nxt = {root_r[51:12], 12'h000};
        req.addr  = fptw_pkg::slot_of(item_r.word_addr);
        case (item_r.action)
          fptw_pkg::ACT_WRITE: begin
            req.wr_en = 1'b1;
            req.wdata = item_r.word_data;
          end
          fptw_pkg::ACT_MAP: begin
            if (item_r.virt_addr[11:0] != '0 || item_r.phys_addr[11:0] != '0)
              res_nxt.status = fptw_pkg::ST_MISALIGN;
          end
          fptw_pkg::ACT_UNMAP: begin
            if (item_r.virt_addr[11:0] != '0) res_nxt.status = fptw_pkg::ST_MISALIGN;
          end
          default: ;
        endcase
      end
      fptw_pkg::S_RD_WAIT: res_nxt.read_data = rdata;
      fptw_pkg::S_EVAL: begin
        if (lvl_r == 2'd3) begin
          if (is_map && rdata[0]) res_nxt.status = fptw_pkg::ST_PRESENT;
          else if (!is_map && !rdata[0]) res_nxt.status = fptw_pkg::ST_PRESENT;
          else if (item_r.action == fptw_pkg::ACT_TRANSLATE)
            res_nxt.result_addr = {rdata[51:12], item_r.virt_addr[11:0]};
        end else if (rdata[0]) begin
          table_nxt = {rdata[51:12], 12'h000};
          lvl_nxt   = lvl_r + 2'd1;
        end else if (is_map && alloc_r < count_r) begin
          frame_nxt = {base_r[51:12] + {33'd0, alloc_r}, 12'h000};
          alloc_nxt = alloc_r + 7'd1;
          zcnt_nxt  = '0;
        end else begin
          res_nxt.status = fptw_pkg::ST_MISSING;
        end
      end
      fptw_pkg::S_ZERO: begin
        req.wr_en = 1'b1;
        req.addr  = {frame_r[12 +: fptw_pkg::FRAME_BITS], zcnt_r};
        zcnt_nxt  = zcnt_r + 9'd1;
      end
      fptw_pkg::S_LINK: begin
        req.wr_en = 1'b1;
        req.wdata = {12'd0, frame_r[51:12], 7'd0, item_r.map_flags[4:1], 1'b1};
        table_nxt = frame_r;
        lvl_nxt   = lvl_r + 2'd1;
      end
      fptw_pkg::S_LEAF: begin
        req.wr_en = 1'b1;
        if (is_map)
          req.wdata = (item_r.map_flags & ~64'h80) | {12'd0, item_r.phys_addr[51:12], 12'h001};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fptw_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      alloc_r     <= '0;
      root_r      <= '0;
      base_r      <= '0;
      count_r     <= '0;
    end else begin
      state_r <= state_nxt;
      alloc_r <= alloc_nxt;
      // result register frees as soon as the transfer completes
      if (state_r == fptw_pkg::S_DONE && (!out_valid_r || out_ready))
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fptw_pkg::CFG_ROOT:  root_r  <= cfg_data[51:0];
          fptw_pkg::CFG_BASE:  base_r  <= cfg_data[51:0];
          fptw_pkg::CFG_COUNT: count_r <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fptw_pkg::S_IDLE && in_valid) item_r <= in_data;
    acc_r <= res_nxt;
    // finished result moves to the output register once it is free
    if (state_r == fptw_pkg::S_DONE && (!out_valid_r || out_ready)) res_r <= acc_r;
    lvl_r   <= lvl_nxt;
    table_r <= table_nxt;
    frame_r <= frame_nxt;
    zcnt_r  <= zcnt_nxt;
  end

  // allocator never passes the configured frame limit while zeroing
  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fptw_pkg::S_ZERO) |-> (alloc_r <= count_r))
    else $error("allocator overran frame count");
  // zeroing only follows a map evaluation or itself
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == fptw_pkg::S_ZERO) |-> $past(state_r == fptw_pkg::S_EVAL) && is_map)
    else $error("zeroing without map");
  // an accepted item always moves the walker into decode
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == fptw_pkg::S_DECODE))
    else $error("accept did not start decode");

endmodule

// ===== rtl/fptw_store.sv =====
// fptw_store: single-port table word memory, registered read
// depends on fptw_pkg
module fptw_store (
  input  logic                 clk,
  input  fptw_pkg::store_req_t req,
  output logic [63:0]          rdata
);

  logic [63:0] mem [fptw_pkg::TABLE_FRAMES*512];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

// ===== sim/tb_four_level_page_table_walker.sv =====
// tb_four_level_page_table_walker: self-checking testbench of the page-table walker
// depends on fptw_pkg and the four_level_page_table_walker rtl; keeps its own table
// store copy to predict each result and drives constrained-by-hand random traffic
module tb_four_level_page_table_walker;
  timeunit 1ns;
  timeprecision 1ps;
  import fptw_pkg::*;

  localparam int NFR = TABLE_FRAMES;
  localparam int NWORDS = NFR * 512;
  localparam logic [51:0] AMASK = 52'hFFFFFFFFFF000;
  localparam logic [51:0] PMAX = 52'hFFFFFFFFFFFFF;
  localparam logic [63:0] LINK_FLAGS = 64'h1E;  // rw, user, pwt, pcd
  localparam logic [63:0] PS_BIT = 64'h80;
  localparam int QUIET_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_ROOT;
  logic [63:0] cfg_data = '0;

  four_level_page_table_walker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table store and the walker registers
  logic [63:0] shadow_tbl [NWORDS];
  bit written [NWORDS];
  logic [51:0] root_r = '0;
  logic [51:0] base_r = '0;
  logic [6:0] limit_r = '0;
  logic [6:0] frames_used = '0;

  out_item_t expected_q[$];
  logic [47:0] mapped_virts[$];
  logic [51:0] touched_addrs[$];
  logic [8:0] top_pool[4];

  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_seen = 1'b0;
  int quiet_cycles = 0;

  function automatic int slot(input logic [51:0] a);
    return int'((a >> 12) % NFR) * 512 + int'(a[11:3]);
  endfunction

  function automatic logic [51:0] entry_addr(input logic [51:0] t, input logic [8:0] idx);
    return t | {40'b0, idx, 3'b0};
  endfunction

  function automatic void put_word(input logic [51:0] a, input logic [63:0] d);
    shadow_tbl[slot(a)] = d;
    written[slot(a)] = 1'b1;
  endfunction

  // upper three levels; creates missing tables when asked to
  function automatic bit walk_upper(input logic [47:0] v, input bit create,
                                    input logic [63:0] fl, output logic [51:0] leaf_tbl);
    logic [51:0] t, ea, fr;
    logic [63:0] e;
    t = root_r & AMASK;
    for (int lv = 0; lv < 3; lv++) begin
      ea = entry_addr(t, v[39 - 9 * lv +: 9]);
      e = shadow_tbl[slot(ea)];
      if (e[0]) begin
        t = e[51:0] & AMASK;
      end else begin
        if (!create || frames_used >= limit_r) return 1'b0;
        fr = ((base_r & AMASK) + {33'b0, frames_used, 12'b0}) & AMASK;
        frames_used = frames_used + 7'd1;
        for (int i = 0; i < 512; i++) put_word(fr | (52'(i) << 3), 64'd0);
        put_word(ea, {12'b0, fr} | (fl & LINK_FLAGS) | 64'd1);
        t = fr;
      end
    end
    leaf_tbl = t;
    return 1'b1;
  endfunction

  // true when the item reads only words that were written before
  function automatic bit reads_known(input in_item_t it);
    logic [51:0] t, ea;
    logic [63:0] e;
    bit misal;
    misal = (it.virt_addr[11:0] != 0);
    case (it.action)
      ACT_READ: return written[slot(it.word_addr)];
      ACT_MAP: if (misal || it.phys_addr[11:0] != 0) return 1'b1;
      ACT_UNMAP: if (misal) return 1'b1;
      ACT_TRANSLATE: ;
      default: return 1'b1;
    endcase
    t = root_r & AMASK;
    for (int lv = 0; lv < 3; lv++) begin
      ea = entry_addr(t, it.virt_addr[39 - 9 * lv +: 9]);
      if (!written[slot(ea)]) return 1'b0;
      e = shadow_tbl[slot(ea)];
      // a missing level either fails or continues in a freshly zeroed frame
      if (!e[0]) return 1'b1;
      t = e[51:0] & AMASK;
    end
    return written[slot(entry_addr(t, it.virt_addr[20:12]))];
  endfunction

  function automatic out_item_t predict_walker(input in_item_t it);
    out_item_t r;
    logic [51:0] pt, la;
    logic [63:0] e;
    logic [47:0] v;
    r = '0;
    v = it.virt_addr;
    case (it.action)
      ACT_WRITE: begin
        put_word(it.word_addr, it.word_data);
        touched_addrs.push_back(it.word_addr);
        if (touched_addrs.size() > 256) void'(touched_addrs.pop_front());
      end
      ACT_READ: r.read_data = shadow_tbl[slot(it.word_addr)];
      ACT_MAP: begin
        if (v[11:0] != 0 || it.phys_addr[11:0] != 0) begin
          r.status = ST_MISALIGN;
        end else if (!walk_upper(v, 1'b1, it.map_flags, pt)) begin
          r.status = ST_MISSING;
        end else begin
          la = entry_addr(pt, v[20:12]);
          if (shadow_tbl[slot(la)][0]) begin
            r.status = ST_PRESENT;
          end else begin
            put_word(la, {12'b0, it.phys_addr & AMASK} | (it.map_flags & ~PS_BIT) | 64'd1);
            mapped_virts.push_back(v);
            if (mapped_virts.size() > 64) void'(mapped_virts.pop_front());
          end
        end
      end
      ACT_UNMAP: begin
        if (v[11:0] != 0) begin
          r.status = ST_MISALIGN;
        end else if (!walk_upper(v, 1'b0, '0, pt)) begin
          r.status = ST_MISSING;
        end else begin
          la = entry_addr(pt, v[20:12]);
          if (!shadow_tbl[slot(la)][0]) r.status = ST_PRESENT;
          else put_word(la, 64'd0);
        end
      end
      ACT_TRANSLATE: begin
        if (!walk_upper(v, 1'b0, '0, pt)) begin
          r.status = ST_MISSING;
        end else begin
          e = shadow_tbl[slot(entry_addr(pt, v[20:12]))];
          if (!e[0]) r.status = ST_PRESENT;
          else r.result_addr = (e[51:0] & AMASK) | {40'b0, v[11:0]};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t item(input logic [2:0] act, input logic [47:0] v,
                                    input logic [51:0] p, input logic [63:0] fl,
                                    input logic [51:0] wa, input logic [63:0] wd);
    in_item_t it;
    it.action = act;
    it.virt_addr = v;
    it.phys_addr = p;
    it.map_flags = fl;
    it.word_addr = wa;
    it.word_data = wd;
    return it;
  endfunction

  // one transfer on the input channel, optionally after an idle gap
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_walker(it));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // register writes only while nothing is in flight
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    idle_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ROOT: root_r = val[51:0];
      CFG_BASE: base_r = val[51:0];
      CFG_COUNT: limit_r = val[6:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // clear the top-level entries that random walks will start from
  task automatic prime_root();
    top_pool[0] = 9'd0;
    top_pool[1] = 9'd511;
    top_pool[2] = 9'($urandom_range(1, 510));
    top_pool[3] = 9'($urandom_range(1, 510));
    mapped_virts.delete();
    for (int i = 0; i < 4; i++)
      send_item(item(ACT_WRITE, '0, '0, '0, entry_addr(root_r & AMASK, top_pool[i]), '0));
  endtask

  function automatic logic [8:0] pick_index();
    case ($urandom_range(3))
      0: return 9'd0;
      1: return 9'd511;
      2: return 9'd7;
      default: return 9'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] pick_virt();
    logic [47:0] v;
    if (mapped_virts.size() != 0 && $urandom_range(99) < 55)
      return mapped_virts[$urandom_range(mapped_virts.size() - 1)];
    v = {top_pool[$urandom_range(3)], pick_index(), pick_index(), 9'($urandom), 12'b0};
    return v;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int k;
    it = item(ACT_WRITE, pick_virt(), 52'({$urandom, $urandom}) & PMAX,
              {$urandom, $urandom}, 52'({$urandom, $urandom}) & PMAX, {$urandom, $urandom});
    if ($urandom_range(9) != 0) it.phys_addr[11:0] = '0;
    k = $urandom_range(99);
    if (k < 12) begin
      it.action = ACT_WRITE;
      if ($urandom_range(1)) it.word_addr = entry_addr(root_r & AMASK, 9'($urandom));
      if ($urandom_range(4) < 3) it.word_data[0] = 1'b0;
    end else if (k < 22) begin
      it.action = ACT_READ;
      if (touched_addrs.size() != 0 && $urandom_range(9) < 8) begin
        it.word_addr = touched_addrs[$urandom_range(touched_addrs.size() - 1)];
        it.word_addr[2:0] = 3'($urandom);
        // higher frame bits alias lower frames
        if ($urandom_range(1)) it.word_addr[51:18] = 34'({$urandom, $urandom});
      end
    end else if (k < 52) begin
      it.action = ACT_MAP;
      if ($urandom_range(19) == 0) it.virt_addr[11:0] = 12'($urandom);
    end else if (k < 67) begin
      it.action = ACT_UNMAP;
      if ($urandom_range(19) == 0) it.virt_addr[11:0] = 12'($urandom);
    end else if (k < 95) begin
      it.action = ACT_TRANSLATE;
      it.virt_addr[11:0] = 12'($urandom);
    end else if (k < 98) begin
      it.action = 3'($urandom_range(5, 7));
    end else begin
      it.action = ACT_TRANSLATE;
      it.virt_addr = 48'({$urandom, $urandom});
    end
    return it;
  endfunction

  task automatic send_random(input int n);
    in_item_t it;
    bit ok;
    for (int i = 0; i < n; i++) begin
      ok = 1'b0;
      for (int t = 0; t < 40 && !ok; t++) begin
        it = random_item();
        ok = reads_known(it);
      end
      // fall back to a store write, which never reads
      if (!ok) it = item(ACT_WRITE, '0, '0, '0, 52'({$urandom, $urandom}) & PMAX, '0);
      send_item(it);
    end
  endtask

  // directed: field extremes, every action and each corner of the walker
  task automatic test_directed_cases();
    logic [51:0] rt;
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_ROOT, 64'h5000);
    write_reg(CFG_BASE, 64'h8000);
    write_reg(CFG_COUNT, 64'd6);
    rt = root_r & AMASK;
    prime_root();
    // walk through an absent top entry
    send_item(item(ACT_TRANSLATE, 48'h0, '0, '0, '0, '0));
    send_item(item(ACT_UNMAP, 48'h1000, '0, '0, '0, '0));
    send_item(item(ACT_UNMAP, 48'h1001, '0, '0, '0, '0));
    // full creation, all flag bits including ps and address bits
    send_item(item(ACT_MAP, 48'h0, 52'hFFFFFFFFFF000, '1, '0, '0));
    send_item(item(ACT_MAP, 48'h0, 52'h1000, '0, '0, '0));
    send_item(item(ACT_TRANSLATE, 48'hFFF, '0, '0, '0, '0));
    send_item(item(ACT_MAP, 48'h800, 52'h2000, '0, '0, '0));
    send_item(item(ACT_MAP, 48'h2000, 52'hFFFFFFFFFFFFF, '0, '0, '0));
    send_item(item(ACT_MAP, 48'hFFFFFFFFF000, 52'h0, '0, '0, '0));
    // allocator now used up
    send_item(item(ACT_MAP, 48'h0000_4000_0000, 52'h3000, 64'h1E, '0, '0));
    send_item(item(ACT_TRANSLATE, 48'h1000, '0, '0, '0, '0));
    send_item(item(ACT_TRANSLATE, 48'hFFFFFFFFFFFF, '0, '0, '0, '0));
    // word access with ignored low bits and an aliased frame
    send_item(item(ACT_READ, '0, '0, '0, (rt + 52'h40000) | 52'h7, '0));
    send_item(item(ACT_WRITE, '0, '0, '0, PMAX, '1));
    send_item(item(ACT_READ, '0, '0, '0, PMAX, '0));
    send_item(item(ACT_UNMAP, 48'h0, '0, '0, '0, '0));
    send_item(item(ACT_TRANSLATE, 48'h0, '0, '0, '0, '0));
    send_item(item(ACT_UNMAP, 48'h0, '0, '0, '0, '0));
    for (int a = 5; a <= 7; a++)
      send_item(item(3'(a), '1, PMAX, '1, PMAX, '1));
  endtask

  task automatic test_no_idle();
    write_reg(CFG_BASE, {12'b0, PMAX});
    write_reg(CFG_COUNT, 64'd40);
    send_idle_pct = 0;
    stall_pct = 0;
    send_random(300);
  endtask

  task automatic test_idle_sender();
    send_idle_pct = 78;
    stall_pct = 0;
    send_random(300);
  endtask

  task automatic test_stalling_receiver();
    write_reg(CFG_ROOT, {12'b0, PMAX});
    write_reg(CFG_BASE, 64'h0);
    write_reg(CFG_COUNT, 64'd64);
    send_idle_pct = 0;
    stall_pct = 78;
    prime_root();
    // long hold-off while items keep coming, so the walker fills and stalls
    hold_go = ~hold_go;
    send_random(300);
  endtask

  task automatic test_both_idle();
    write_reg(CFG_ROOT, 64'h0);
    write_reg(CFG_BASE, 64'h20000);
    send_idle_pct = 13;
    stall_pct = 13;
    prime_root();
    send_random(300);
  endtask

  task automatic test_allocator_off();
    write_reg(CFG_COUNT, 64'd0);
    send_idle_pct = 0;
    stall_pct = 0;
    send_random(130);
  endtask

  // receiver side ready pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result check against the oldest prediction, plus the quiet-cycle watchdog
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data.status !== exp_r.status) begin
            $display("%0t: status exp %h act %h", $time, exp_r.status, out_data.status);
            errors++;
          end
          if (out_data.result_addr !== exp_r.result_addr) begin
            $display("%0t: result_addr exp %h act %h", $time, exp_r.result_addr,
                     out_data.result_addr);
            errors++;
          end
          if (out_data.read_data !== exp_r.read_data) begin
            $display("%0t: read_data exp %h act %h", $time, exp_r.read_data,
                     out_data.read_data);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_no_idle();
    test_idle_sender();
    test_stalling_receiver();
    test_both_idle();
    test_allocator_off();
    idle_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
